// File: rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock with lockout.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

	localparam int NIB_W      = 4;
	localparam int CODE_W     = 16;
	localparam int CODE_NIBS  = CODE_W / NIB_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ATT_W      = 4;

	// key codes
	localparam logic [NIB_W-1:0] DIGIT_LIMIT = 4'd10;
	localparam logic [NIB_W-1:0] KEY_STAR    = 4'd10;
	localparam logic [NIB_W-1:0] KEY_HASH    = 4'd11;
	localparam logic [NIB_W-1:0] SLOT_EMPTY  = 4'd10;

	// lock modes; bit 1 marks blocked
	localparam logic [1:0] LOCK_LOCKED   = 2'd0;
	localparam logic [1:0] LOCK_UNLOCKED = 2'd1;
	localparam int         BLOCK_BIT     = 1;

	localparam logic [1:0] VERDICT_NONE    = 2'd0;
	localparam logic [1:0] VERDICT_ALLOWED = 2'd1;
	localparam logic [1:0] VERDICT_DENIED  = 2'd2;

	localparam logic [ATT_W-1:0] ATTEMPT_INIT = 4'd1;
	localparam logic [ATT_W-1:0] ATTEMPT_MAX  = 4'd15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USER_CODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECURITY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd2;

	localparam logic [CODE_W-1:0] USER_CODE_RST    = 16'h1157;
	localparam logic [CODE_W-1:0] SECURITY_RST     = 16'h4321;
	localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST = 4'd3;

	typedef struct packed {
		logic [1:0] lock_state;
		logic [1:0] verdict;
		logic [2:0] digits_entered;
		logic       green_led;
		logic       blue_led;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/kcl_key_if.sv
// ----------------------------------------------------------------------------
// kcl_key_if
// Keypad scan sample channel: one request per scan sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_key_if import kcl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             key_present;
	logic [NIB_W-1:0] key_code;

	modport source (output valid, output key_present, output key_code, input ready);
	modport sink   (input valid, input key_present, input key_code, output ready);
	modport mon    (input valid, input key_present, input key_code, input ready);
endinterface

`default_nettype wire

// File: rtl/kcl_res_if.sv
// ----------------------------------------------------------------------------
// kcl_res_if
// Lock status channel: one request per scan sample handled.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] lock_state;
	logic [1:0] verdict;
	logic [2:0] digits_entered;
	logic       green_led;
	logic       blue_led;

	modport source (output valid, output lock_state, output verdict, output digits_entered,
		output green_led, output blue_led, input ready);
	modport sink   (input valid, input lock_state, input verdict, input digits_entered,
		input green_led, input blue_led, output ready);
	modport mon    (input valid, input lock_state, input verdict, input digits_entered,
		input green_led, input blue_led, input ready);
endinterface

`default_nettype wire

// File: rtl/kcl_cfg_if.sv
// ----------------------------------------------------------------------------
// kcl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_cfg_if import kcl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
	modport mon    (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

// File: rtl/kcl_match.sv
// ----------------------------------------------------------------------------
// kcl_match
// Parallel compare of the entry buffer against a packed BCD code.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_match import kcl_pkg::*; #(
	parameter int CODE_DIGITS = 4
) (
	input  wire logic [CODE_DIGITS-1:0][NIB_W-1:0] entry,
	input  wire logic [CODE_W-1:0]                 code,
	output logic                                   hit
);

	logic [CODE_DIGITS-1:0] eq;

	// code digits past the packed word count as zero
	for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_dig
		if (i < CODE_NIBS) begin : g_code
			assign eq[i] = (entry[i] == code[i*NIB_W +: NIB_W]);
		end else begin : g_zero
			assign eq[i] = (entry[i] == '0);
		end
	end

	assign hit = &eq;

endmodule

`default_nettype wire

// File: rtl/keypad_code_lock_with_lockout.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout
// Keypad code lock: edge-detected key presses fill an entry buffer, hash
// checks it against the user or security code, wrong codes lead to lockout.
// ----------------------------------------------------------------------------
// An accepted scan sample's status request is registered and offered in the next cycle.
// Throughput: 1 sample per cycle; the status register is the only stage and
// a new sample is taken whenever it is empty or being drained that cycle.
// Reset: arst_n clears lock state and entry buffer, resets the attempt count and
// loads the default codes and attempt limit; no clearing pass, and the scan sample channel is ready out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_with_lockout import kcl_pkg::*; #(
	parameter int CODE_DIGITS = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kcl_key_if.sink    key,
	kcl_res_if.source  res,
	kcl_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(CODE_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

	logic [CODE_W-1:0]                 user_q;
	logic [CODE_W-1:0]                 sec_q;
	logic [ATT_W-1:0]                  max_q;
	logic [CODE_DIGITS-1:0][NIB_W-1:0] ent_q, ent_d;
	logic [CNT_W-1:0]                  cnt_q, cnt_d;
	logic [1:0]                        mode_q, mode_d;
	logic [ATT_W-1:0]                  att_q, att_d;
	logic                              was_down_q;
	res_t                              res_q, res_d;
	logic                              res_valid_q;

	logic       in_fire;
	logic       new_press;
	logic       blocked;
	logic       hit;
	logic [1:0] verdict;
	logic [3:0] cnt_ext;

	assign cfg.ready = 1'b1;
	assign key.ready = !res_valid_q || res.ready;
	assign in_fire   = key.valid && key.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q <= USER_CODE_RST;
			sec_q  <= SECURITY_RST;
			max_q  <= MAX_ATTEMPTS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_USER_CODE:    user_q <= cfg.data[CODE_W-1:0];
				CFG_SECURITY:     sec_q  <= cfg.data[CODE_W-1:0];
				CFG_MAX_ATTEMPTS: max_q  <= cfg.data[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	assign blocked   = mode_q[BLOCK_BIT];
	assign new_press = key.key_present && !was_down_q;

	kcl_match #(.CODE_DIGITS(CODE_DIGITS)) u_match (
		.entry (ent_q),
		.code  (blocked ? sec_q : user_q),
		.hit   (hit)
	);

	always_comb begin
		ent_d   = ent_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		att_d   = att_q;
		verdict = VERDICT_NONE;
		if (new_press) begin
			if (key.key_code < DIGIT_LIMIT) begin
				if (cnt_q < CNT_FULL) begin
					for (int i = 0; i < CODE_DIGITS; i++) begin
						if (cnt_q == CNT_W'(i)) begin
							ent_d[i] = key.key_code;
						end
					end
					cnt_d = cnt_q + 1'b1;
				end
			end else if (key.key_code == KEY_STAR) begin
				ent_d = {CODE_DIGITS{SLOT_EMPTY}};
				cnt_d = '0;
			end else if (key.key_code == KEY_HASH) begin
				if (hit) begin
					mode_d  = blocked ? (mode_q & LOCK_UNLOCKED) : (mode_q ^ LOCK_UNLOCKED);
					att_d   = ATTEMPT_INIT;
					verdict = VERDICT_ALLOWED;
				end else begin
					att_d   = (att_q < ATTEMPT_MAX) ? att_q + 1'b1 : att_q;
					verdict = VERDICT_DENIED;
				end
				// limit check applies after a match too
				if (att_d > max_q) begin
					mode_d[BLOCK_BIT] = 1'b1;
				end
				ent_d = {CODE_DIGITS{SLOT_EMPTY}};
				cnt_d = '0;
			end
		end
	end

	assign cnt_ext = 4'(cnt_d);

	always_comb begin
		res_d.lock_state     = mode_d;
		res_d.verdict        = verdict;
		res_d.digits_entered = cnt_ext[2:0];
		res_d.green_led      = (mode_d == LOCK_UNLOCKED);
		res_d.blue_led       = (mode_d == LOCK_LOCKED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q      <= {CODE_DIGITS{SLOT_EMPTY}};
			cnt_q      <= '0;
			mode_q     <= LOCK_LOCKED;
			att_q      <= ATTEMPT_INIT;
			was_down_q <= 1'b0;
		end else if (in_fire) begin
			ent_q      <= ent_d;
			cnt_q      <= cnt_d;
			mode_q     <= mode_d;
			att_q      <= att_d;
			was_down_q <= key.key_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.lock_state     = res_q.lock_state;
	assign res.verdict        = res_q.verdict;
	assign res.digits_entered = res_q.digits_entered;
	assign res.green_led      = res_q.green_led;
	assign res.blue_led       = res_q.blue_led;

endmodule

`default_nettype wire

// File: rtl/kcl_chk.sv
// ----------------------------------------------------------------------------
// kcl_chk
// Port-level checks for the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_chk import kcl_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       key_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] res_lock_state,
	input wire logic [1:0] res_verdict,
	input wire logic [2:0] res_digits_entered,
	input wire logic       res_green_led,
	input wire logic       res_blue_led
);

	// LEDs decode the lock state
	a_leds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_green_led == (res_lock_state == LOCK_UNLOCKED)) &&
			(res_blue_led == (res_lock_state == LOCK_LOCKED)))
		else $error("kcl: LED outputs disagree with lock_state");

	// a check always empties the entry buffer
	a_check_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_verdict != VERDICT_NONE) |-> (res_digits_entered == 3'd0))
		else $error("kcl: entry buffer not cleared after a check");

	// a stalled status request blocks new samples
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !key_ready)
		else $error("kcl: sample accepted while status is stalled");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_lock_state) &&
			$stable(res_verdict) && $stable(res_digits_entered))
		else $error("kcl: stalled status request changed");

endmodule

bind keypad_code_lock_with_lockout kcl_chk u_kcl_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.key_ready          (key.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_lock_state     (res.lock_state),
	.res_verdict        (res.verdict),
	.res_digits_entered (res.digits_entered),
	.res_green_led      (res.green_led),
	.res_blue_led       (res.blue_led)
);

`default_nettype wire

// File: bench/kcl_lock_checker.sv
// ----------------------------------------------------------------------------
// kcl_lock_checker
// Watches the scan sample, status and configuration channels of the keypad
// code lock. It keeps its own copy of the lock state and predicts the status
// request for every accepted scan sample. Each status request is then compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module kcl_lock_checker import kcl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	kcl_key_if.mon key,
	kcl_res_if.mon res,
	kcl_cfg_if.mon cfg,
	output int     fail_count,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CODE_W-1:0] user_code;
	logic [CODE_W-1:0] security_code;
	logic [ATT_W-1:0]  max_tries;

	logic [NIB_W-1:0]  slots [CODE_NIBS];
	logic [2:0]        n_digits;
	logic [1:0]        mode;
	logic [ATT_W-1:0]  attempts;
	logic              was_down;

	res_t status_q [$];

	task automatic clear_entry();
		for (int i = 0; i < CODE_NIBS; i++)
			slots[i] = SLOT_EMPTY;
		n_digits = '0;
	endtask

	// only a fresh press acts; a held key or a release just updates was_down
	task automatic take_scan_sample(input logic present, input logic [NIB_W-1:0] k,
		output res_t r);
		logic [CODE_W-1:0] target;
		logic              hit;
		logic [1:0]        verdict;

		verdict = VERDICT_NONE;
		if (present && !was_down) begin
			if (k < DIGIT_LIMIT) begin
				if (n_digits < CODE_NIBS) begin
					slots[n_digits] = k;
					n_digits++;
				end
			end else if (k == KEY_STAR) begin
				clear_entry();
			end else if (k == KEY_HASH) begin
				target = mode[BLOCK_BIT] ? security_code : user_code;
				hit = 1'b1;
				// empty slots hold the empty marker and are compared as such
				for (int i = 0; i < CODE_NIBS; i++)
					if (slots[i] != target[i*NIB_W +: NIB_W])
						hit = 1'b0;
				if (hit) begin
					if (mode[BLOCK_BIT])
						mode[BLOCK_BIT] = 1'b0;
					else
						mode[0] = ~mode[0];
					attempts = ATTEMPT_INIT;
					verdict = VERDICT_ALLOWED;
				end else begin
					if (attempts < ATTEMPT_MAX)
						attempts++;
					verdict = VERDICT_DENIED;
				end
				// checked even after a match, so a limit of zero blocks at once
				if (attempts > max_tries)
					mode[BLOCK_BIT] = 1'b1;
				clear_entry();
			end
		end
		was_down = present;

		r.lock_state     = mode;
		r.verdict        = verdict;
		r.digits_entered = n_digits;
		r.green_led      = (mode == LOCK_UNLOCKED);
		r.blue_led       = (mode == LOCK_LOCKED);
	endtask

	task automatic check_field(input string field, input logic [3:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;

		if (!arst_n) begin
			user_code     = USER_CODE_RST;
			security_code = SECURITY_RST;
			max_tries     = MAX_ATTEMPTS_RST;
			clear_entry();
			mode     = LOCK_LOCKED;
			attempts = ATTEMPT_INIT;
			was_down = 1'b0;
			status_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_USER_CODE:    user_code = cfg.data;
					CFG_SECURITY:     security_code = cfg.data;
					CFG_MAX_ATTEMPTS: max_tries = cfg.data[ATT_W-1:0];
					default: ;
				endcase
			end

			// the status request is registered, so a status request never pairs with a
			// sample taken at the same edge
			if (res.valid && res.ready) begin
				if (status_q.size() == 0) begin
					$error("status request with no scan sample pending");
					fail_count++;
				end else begin
					want = status_q.pop_front();
					check_field("lock_state", 4'(want.lock_state), 4'(res.lock_state));
					check_field("verdict", 4'(want.verdict), 4'(res.verdict));
					check_field("digits_entered", 4'(want.digits_entered),
						4'(res.digits_entered));
					check_field("green_led", 4'(want.green_led), 4'(res.green_led));
					check_field("blue_led", 4'(want.blue_led), 4'(res.blue_led));
				end
			end

			if (key.valid && key.ready) begin
				take_scan_sample(key.key_present, key.key_code, want);
				status_q.push_back(want);
			end

			outstanding <= status_q.size();
		end
	end

endmodule

// File: bench/keypad_code_lock_with_lockout_tb.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout_tb
// Drives keypad scan samples and register writes into the code lock and
// stalls the status channel at random. A short directed key sequence comes
// first, then code entries, wrong codes, clears and noise under several code
// and attempt limit settings. The checker predicts and compares each status
// request.
// ----------------------------------------------------------------------------

module keypad_code_lock_with_lockout_tb import kcl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 110;
	localparam int PHASE_COUNT  = 7;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLIPS} rx_mode_t;

	logic clk;
	logic arst_n;

	kcl_key_if key_ch ();
	kcl_res_if res_ch ();
	kcl_cfg_if cfg_ch ();

	int fail_count;
	int outstanding;
	int cycle_count  = 0;
	int samples_sent = 0;
	int burst_left   = 0;

	rx_mode_t rx_mode   = RX_OPEN;
	int       rx_left   = 0;

	keypad_code_lock_with_lockout dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	kcl_lock_checker lock_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// status stalls follow a mode that is redrawn at random when its countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   res_ch.ready <= 1'b1;
			RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
			default:   res_ch.ready <= (rx_left % 8 != 0);
		endcase
	end

	function automatic logic [CODE_W-1:0] rand_bcd();
		logic [CODE_W-1:0] c;

		for (int i = 0; i < CODE_NIBS; i++)
			c[i*NIB_W +: NIB_W] = NIB_W'($urandom_range(0, 9));
		return c;
	endfunction

	task automatic send(input logic present, input logic [NIB_W-1:0] k);
		int gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				key_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		key_ch.valid       <= 1'b1;
		key_ch.key_present <= present;
		key_ch.key_code    <= k;
		do @(posedge clk); while (!key_ch.ready);
		samples_sent++;
	endtask

	// press, sometimes hold, then release with a junk code
	task automatic tap(input logic [NIB_W-1:0] k);
		send(1'b1, k);
		if ($urandom_range(0, 5) == 0)
			send(1'b1, NIB_W'($urandom_range(0, 15)));
		send(1'b0, NIB_W'($urandom_range(0, 15)));
	endtask

	task automatic drain();
		key_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_regs(input logic [CODE_W-1:0] user, sec, input logic [ATT_W-1:0] tries);
		logic [CFG_IDX_W-1:0] regs [3] = '{CFG_USER_CODE, CFG_SECURITY, CFG_MAX_ATTEMPTS};

		for (int r = 0; r < 3; r++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[r];
			case (regs[r])
				CFG_USER_CODE: cfg_ch.data <= user;
				CFG_SECURITY:  cfg_ch.data <= sec;
				default:       cfg_ch.data <= {{(CFG_DATA_W-ATT_W){1'b0}}, tries};
			endcase
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic key_sequence(input logic [CODE_W-1:0] user, sec);
		logic [CODE_W-1:0] code;
		int                kind;
		int                n;

		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			code = (kind < 35) ? user : sec;
			// a non-digit nibble ends the entry short; trailing empties can match
			for (int i = 0; i < CODE_NIBS; i++) begin
				if (code[i*NIB_W +: NIB_W] >= DIGIT_LIMIT)
					break;
				tap(code[i*NIB_W +: NIB_W]);
			end
			if ($urandom_range(0, 9) == 0)
				tap(NIB_W'($urandom_range(0, 9)));
			tap(KEY_HASH);
		end else if (kind < 75) begin
			n = $urandom_range(0, 5);
			repeat (n) tap(NIB_W'($urandom_range(0, 9)));
			tap(KEY_HASH);
		end else if (kind < 85) begin
			n = $urandom_range(1, 4);
			repeat (n) tap(NIB_W'($urandom_range(0, 9)));
			tap(KEY_STAR);
			if ($urandom_range(0, 1) == 0)
				tap(KEY_HASH);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send(1'($urandom_range(0, 1)), NIB_W'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		logic [CODE_W-1:0] user_now;
		logic [CODE_W-1:0] sec_now;
		logic [ATT_W-1:0]  tries_now;
		int                phase_goal;

		arst_n             <= 1'b0;
		key_ch.valid       <= 1'b0;
		key_ch.key_present <= 1'b0;
		key_ch.key_code    <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_USER_CODE;
		cfg_ch.data        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		user_now  = USER_CODE_RST;
		sec_now   = SECURITY_RST;
		tries_now = MAX_ATTEMPTS_RST;

		// held key, default code, buffer full, unused keys, clear, empty check
		send(1'b1, 4'd7);
		send(1'b1, 4'd7);
		send(1'b0, 4'd15);
		tap(4'd5);
		tap(4'd1);
		tap(4'd1);
		tap(4'd9);
		tap(KEY_HASH);
		tap(4'd12);
		tap(4'd15);
		tap(4'd0);
		tap(KEY_STAR);
		tap(KEY_HASH);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				1: begin user_now = 16'h0000;   sec_now = 16'h9999;   tries_now = 4'd1;  end
				2: begin user_now = 16'hAAAA;   sec_now = 16'hFFFF;   tries_now = 4'd14; end
				3: begin user_now = rand_bcd(); sec_now = 16'hAA39;   tries_now = 4'd0;  end
				4: begin user_now = rand_bcd(); sec_now = rand_bcd(); tries_now = 4'd15; end
				5: begin
					user_now  = CODE_W'($urandom_range(0, 16'hFFFF));
					sec_now   = rand_bcd();
					tries_now = ATT_W'($urandom_range(0, 15));
				end
				6: begin user_now = rand_bcd(); sec_now = 16'h0000;   tries_now = 4'd3;  end
				default: ;
			endcase
			if (ph > 0) begin
				drain();
				write_regs(user_now, sec_now, tries_now);
			end
			phase_goal = samples_sent + PHASE_ITEMS;
			while (samples_sent < phase_goal) begin
				key_sequence(user_now, sec_now);
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
